@@ rtl/core/wspa_pkg.sv @@
// wspa_pkg: shared types and codes of the slot pool allocator
// used by wspa_ctrl, wspa_dp and watch_slot_pool_allocator
package wspa_pkg;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_NOT_ACTIVE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RD_FREE_HEAD   = 2'd0,
        RD_ACTIVE_HEAD = 2'd1,
        RD_NEXT        = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    init_step;
        logic    take_req;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    pop_free;
        logic    free_from_next;
        logic    active_from_s;
        logic    cur_from_active;
        logic    advance;
        logic    wr_tail;
        logic    unlink;
        logic    push_free;
        logic    term_s;
        logic    set_res;
        t_status res_code;
        logic    res_grant;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic init_last;
        logic free_null;
        logic active_null;
        logic next_null;
        logic match;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/core/wspa_ram.sv @@
// wspa_ram: generic single-write, single-read ram with registered read
// no dependencies
module wspa_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/wspa_dp.sv @@
// wspa_dp: list heads, walk pointers, link store and output register
// depends on wspa_pkg and wspa_ram
module wspa_dp
    import wspa_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    input  logic [4:0] i_slot_number,
    input  logic       i_m_tready,
    output logic       o_m_tvalid,
    output logic [7:0] o_m_tdata
);

    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int CW = (LW > 5) ? LW : 5;
    localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);

    logic [LW-1:0] r_free_head;
    logic [LW-1:0] r_active_head;
    logic [LW-1:0] r_cur;
    logic [LW-1:0] r_prev;
    logic [LW-1:0] r_s;
    logic [4:0]    r_target;
    logic [IW-1:0] r_init_idx;
    t_status       r_res_status;
    logic [4:0]    r_res_slot;
    logic          r_out_valid;
    t_status       r_out_status;
    logic [4:0]    r_out_slot;

    logic [LW-1:0] rd_data;
    logic [LW-1:0] next_val;
    logic [LW-1:0] rd_link;
    logic          wr_en;
    logic [LW-1:0] wr_addr;
    logic [LW-1:0] wr_data;
    logic          out_free;

    assign next_val = (rd_data >= NULL_LINK) ? NULL_LINK : rd_data;
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_FREE_HEAD:   rd_link = r_free_head;
            RD_ACTIVE_HEAD: rd_link = r_active_head;
            default:        rd_link = next_val;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_cur;
        wr_data = r_s;
        if (i_cmd.init_step) begin
            wr_addr = LW'(r_init_idx);
            wr_data = LW'(r_init_idx) + LW'(1);
        end else if (i_cmd.wr_tail) begin
            wr_addr = r_cur;
            wr_data = r_s;
        end else if (i_cmd.unlink && r_prev != NULL_LINK) begin
            wr_addr = r_prev;
            wr_data = next_val;
        end else if (i_cmd.push_free) begin
            wr_addr = r_cur;
            wr_data = r_free_head;
        end else if (i_cmd.term_s) begin
            wr_addr = r_s;
            wr_data = NULL_LINK;
        end else begin
            wr_en = 1'b0;
        end
    end

    wspa_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_link_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr[IW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_link[IW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head   <= '0;
            r_active_head <= NULL_LINK;
            r_init_idx    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.init_step) begin
                r_init_idx <= r_init_idx + IW'(1);
            end
            if (i_cmd.free_from_next) begin
                r_free_head <= next_val;
            end else if (i_cmd.push_free) begin
                r_free_head <= r_cur;
            end
            if (i_cmd.active_from_s) begin
                r_active_head <= r_s;
            end else if (i_cmd.unlink && r_prev == NULL_LINK) begin
                r_active_head <= next_val;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_target <= i_slot_number;
        end
        if (i_cmd.pop_free) begin
            r_s <= r_free_head;
        end
        if (i_cmd.cur_from_active) begin
            r_cur  <= r_active_head;
            r_prev <= NULL_LINK;
        end else if (i_cmd.advance) begin
            r_prev <= r_cur;
            r_cur  <= next_val;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_code;
            r_res_slot   <= i_cmd.res_grant ? 5'(r_s) : 5'd0;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
        end
    end

    assign o_stat.init_last   = (r_init_idx == IW'(SLOTS - 1));
    assign o_stat.free_null   = (r_free_head >= NULL_LINK);
    assign o_stat.active_null = (r_active_head >= NULL_LINK);
    assign o_stat.next_null   = (rd_data >= NULL_LINK);
    assign o_stat.match       = (CW'(r_cur) == CW'(r_target));
    assign o_stat.out_free    = out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_slot, r_out_status};

endmodule

@@ rtl/core/wspa_ctrl.sv @@
// wspa_ctrl: sequencer for link store init, allocate and free walks
// depends on wspa_pkg
module wspa_ctrl
    import wspa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_req     i_in_req,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_AL_POP,
        S_AL_NEXT,
        S_AL_WALK,
        S_AL_TERM,
        S_FR_START,
        S_FR_WALK,
        S_FR_PUSH,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_stat.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    o_cmd.take_req = 1'b1;
                    n_state = (i_in_req == REQ_FREE) ? S_FR_START : S_AL_POP;
                end
            end
            S_AL_POP: begin
                if (i_stat.free_null) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_EMPTY;
                    n_state = S_RESP;
                end else begin
                    o_cmd.pop_free = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_sel   = RD_FREE_HEAD;
                    n_state = S_AL_NEXT;
                end
            end
            S_AL_NEXT: begin
                o_cmd.free_from_next = 1'b1;
                if (i_stat.active_null) begin
                    o_cmd.active_from_s = 1'b1;
                    n_state = S_AL_TERM;
                end else begin
                    o_cmd.cur_from_active = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_ACTIVE_HEAD;
                    n_state = S_AL_WALK;
                end
            end
            S_AL_WALK: begin
                if (i_stat.next_null) begin
                    o_cmd.wr_tail = 1'b1;
                    n_state = S_AL_TERM;
                end else begin
                    o_cmd.advance = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = RD_NEXT;
                end
            end
            S_AL_TERM: begin
                o_cmd.term_s    = 1'b1;
                o_cmd.set_res   = 1'b1;
                o_cmd.res_code  = ST_DONE;
                o_cmd.res_grant = 1'b1;
                n_state = S_RESP;
            end
            S_FR_START: begin
                if (i_stat.active_null) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_NOT_ACTIVE;
                    n_state = S_RESP;
                end else begin
                    o_cmd.cur_from_active = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_ACTIVE_HEAD;
                    n_state = S_FR_WALK;
                end
            end
            S_FR_WALK: begin
                if (i_stat.match) begin
                    o_cmd.unlink = 1'b1;
                    n_state = S_FR_PUSH;
                end else if (i_stat.next_null) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_NOT_ACTIVE;
                    n_state = S_RESP;
                end else begin
                    o_cmd.advance = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = RD_NEXT;
                end
            end
            S_FR_PUSH: begin
                o_cmd.push_free = 1'b1;
                o_cmd.set_res   = 1'b1;
                o_cmd.res_code  = ST_DONE;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_in_ready = r_ready;

endmodule

@@ rtl/core/watch_slot_pool_allocator.sv @@
// watch_slot_pool_allocator: free-list slot allocator, top level
// allocate walks the active list to its tail to append the popped slot, or reports empty;
// free walks the active list up to the named slot, or reports not active if it is absent
// one item in flight; the next item is accepted only after the result register loads
// after reset an init pass fills the link store with tready low
// depends on wspa_pkg, wspa_ctrl, wspa_dp, wspa_ram
module watch_slot_pool_allocator
    import wspa_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // slot_number[4:0], zero pad
    input  logic [0:0] s_axis_tuser,   // req_type[0]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // status[1:0], granted_slot[6:2], zero pad
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_req     in_req;

    assign in_req = t_req'(s_axis_tuser[0]);

    wspa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_req   (in_req),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wspa_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_slot_number (s_axis_tdata[4:0]),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_m_tdata     (m_axis_tdata)
    );

endmodule
